[rtl/ffba_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffba_pkg
// Shared widths, register indexes, command codes and the leaf status word of
// the first-fit bin allocator.
// -----------------------------------------------------------------------------
package ffba_pkg;

  // fixed field widths
  localparam int REQ_W     = 16;  // request_size
  localparam int BIN_W     = 11;  // bin_number
  localparam int CFG_W     = 16;  // widest config register
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 16;  // item count / item_limit
  localparam int NB_W      = 11;  // num_bins register

  // parameter defaults
  localparam int NUM_BINS_DEF   = 1024;
  localparam int SIZE_WIDTH_DEF = 16;

  // config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_CAPACITY = 2'd0,
    REG_ITEM_LIMIT   = 2'd1,
    REG_NUM_BINS     = 2'd2
  } cfg_reg_t;

  // register reset values
  localparam logic [CFG_W-1:0] BIN_CAP_RST    = 16'd0;
  localparam logic [CNT_W-1:0] ITEM_LIMIT_RST = 16'd1;
  localparam logic [NB_W-1:0]  NUM_BINS_RST   = 11'd1024;

  // commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // leaf decision, registered from the leaf read data
  typedef struct packed {
    logic valid;
    logic found;
  } leaf_res_t;

endpackage

[rtl/ffba_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffba_req_if / ffba_res_if
// Valid/ready channels for request words and result words.
// -----------------------------------------------------------------------------
interface ffba_req_if import ffba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [REQ_W-1:0] request_size;

  modport source (output valid, cmd, request_size, input ready);
  modport sink   (input valid, cmd, request_size, output ready);
endinterface

interface ffba_res_if import ffba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [BIN_W-1:0] bin_number;

  modport source (output valid, found, bin_number, input ready);
  modport sink   (input valid, found, bin_number, output ready);
endinterface

[rtl/ffba_ram.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffba_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// -----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [0:(1 << AW)-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/ffba_cell.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffba_cell
// One internal level of the max tree. Each entry holds the maxima of the two
// child subtrees. Steers the search token down, folds the update back up.
// -----------------------------------------------------------------------------
module ffba_cell #(
  parameter int LEVEL = 0,
  parameter int IW    = 10,
  parameter int SW    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  // clearing sweep, broadcast
  input  logic          sw_active,
  input  logic [IW-1:0] sw_idx,
  input  logic [SW-1:0] sw_cap,
  input  logic [IW:0]   sw_used,
  // size under search
  input  logic [SW-1:0] size,
  // search token from the level above / to the level below
  input  logic          dn_valid,
  input  logic [IW-1:0] dn_idx,
  output logic          dn_out_valid,
  output logic [IW-1:0] dn_out_idx,
  // update from the level below / to the level above
  input  logic          up_valid,
  input  logic [SW-1:0] up_val,
  output logic          up_out_valid,
  output logic [SW-1:0] up_out_val
);

  localparam int AW = (LEVEL > 0) ? LEVEL : 1;
  localparam int SH = IW - LEVEL;

  logic            rd_pend_r;
  logic [IW-1:0]   idx_r;
  logic [2*SW-1:0] rd_data;
  logic [2*SW-1:0] entry_r;
  logic            dir_r;
  logic            up_valid_r;
  logic [SW-1:0]   up_val_r;

  logic [SW-1:0]   lmax;
  logic            go_right;
  logic [SW-1:0]   other;
  logic [2*SW-1:0] up_entry;
  logic [IW-1:0]   sw_node;
  logic [IW:0]     sw_lstart;
  logic [IW:0]     sw_rstart;
  logic [2*SW-1:0] sw_entry;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [2*SW-1:0] wdata;

  assign lmax     = rd_data[2*SW-1:SW];
  assign go_right = lmax < size;

  assign dn_out_valid = rd_pend_r;
  assign dn_out_idx   = IW'({idx_r, go_right});

  // sibling max kept from the descent
  assign other    = dir_r ? entry_r[2*SW-1:SW] : entry_r[SW-1:0];
  assign up_entry = dir_r ? {other, up_val} : {up_val, other};

  // entry on clear: each child max is full if that child's first leaf is in use
  assign sw_node   = sw_idx >> SH;
  assign sw_lstart = {1'b0, sw_node} << SH;
  assign sw_rstart = sw_lstart + ((IW+1)'(1) << (SH - 1));
  assign sw_entry  = {(sw_lstart < sw_used) ? sw_cap : {SW{1'b0}},
                      (sw_rstart < sw_used) ? sw_cap : {SW{1'b0}}};

  assign we    = sw_active | up_valid;
  assign waddr = sw_active ? sw_node[AW-1:0] : idx_r[AW-1:0];
  assign wdata = sw_active ? sw_entry : up_entry;

  ffba_ram #(
    .WIDTH (2*SW),
    .DEPTH (1 << LEVEL)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (dn_idx[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r  <= 1'b0;
      up_valid_r <= 1'b0;
    end else begin
      rd_pend_r  <= dn_valid;
      up_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dn_valid) begin
      idx_r <= dn_idx;
    end
    if (rd_pend_r) begin
      entry_r <= rd_data;
      dir_r   <= go_right;
    end
    up_val_r <= (other > up_val) ? other : up_val;
  end

  assign up_out_valid = up_valid_r;
  assign up_out_val   = up_val_r;

endmodule

[rtl/ffba_leaf.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffba_leaf
// Leaf level: remaining capacity and item count per bin. Decides the fit,
// updates the bin and starts the update back up the tree.
// -----------------------------------------------------------------------------
module ffba_leaf import ffba_pkg::*; #(
  parameter int IW = 10,
  parameter int SW = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             sw_active,
  input  logic [IW-1:0]    sw_idx,
  input  logic [SW-1:0]    sw_cap,
  input  logic [IW:0]      sw_used,
  input  logic [SW-1:0]    size,
  input  logic [IW:0]      used,
  input  logic [CNT_W-1:0] item_limit,
  input  logic             dn_valid,
  input  logic [IW-1:0]    dn_idx,
  output leaf_res_t        res,
  output logic [IW-1:0]    res_idx,
  output logic             up_out_valid,
  output logic [SW-1:0]    up_out_val
);

  logic             rd_pend_r;
  logic [IW-1:0]    idx_r;
  leaf_res_t        res_r;
  logic [IW-1:0]    res_idx_r;
  logic             up_valid_r;
  logic [SW-1:0]    up_val_r;

  logic [SW-1:0]    cap;
  logic [CNT_W-1:0] cnt;
  logic             fit;
  logic [CNT_W-1:0] cnt_inc;
  logic [SW-1:0]    new_cap;
  logic             we;
  logic [IW-1:0]    waddr;
  logic [SW-1:0]    cap_wdata;
  logic [CNT_W-1:0] cnt_wdata;

  assign fit     = (cap >= size) && ({1'b0, idx_r} < used);
  assign cnt_inc = cnt + 1'b1;
  // bin closes when its count hits the limit
  assign new_cap = (cnt_inc == item_limit) ? {SW{1'b0}} : cap - size;

  assign we        = sw_active | (rd_pend_r & fit);
  assign waddr     = sw_active ? sw_idx : idx_r;
  assign cap_wdata = sw_active ? (({1'b0, sw_idx} < sw_used) ? sw_cap : {SW{1'b0}})
                               : new_cap;
  assign cnt_wdata = sw_active ? {CNT_W{1'b0}} : cnt_inc;

  ffba_ram #(
    .WIDTH (SW),
    .DEPTH (1 << IW)
  ) u_cap_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cap_wdata),
    .raddr (dn_idx),
    .rdata (cap)
  );

  ffba_ram #(
    .WIDTH (CNT_W),
    .DEPTH (1 << IW)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cnt_wdata),
    .raddr (dn_idx),
    .rdata (cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r  <= 1'b0;
      up_valid_r <= 1'b0;
      res_r      <= '0;
    end else begin
      rd_pend_r   <= dn_valid;
      up_valid_r  <= rd_pend_r;
      res_r.valid <= rd_pend_r;
      res_r.found <= fit;
    end
  end

  always_ff @(posedge clk) begin
    if (dn_valid) begin
      idx_r <= dn_idx;
    end
    res_idx_r   <= idx_r;
    up_val_r    <= fit ? new_cap : cap;
  end

  assign res          = res_r;
  assign res_idx      = res_idx_r;
  assign up_out_valid = up_valid_r;
  assign up_out_val   = up_val_r;

endmodule

[rtl/first_fit_bin_allocator.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// first_fit_bin_allocator
// Places each request in the lowest numbered bin with enough room, using a
// max tree held as a row of level cells, one RAM per cell level, two at the leaves.
// -----------------------------------------------------------------------------
//
//  channel   dir  handshake       payload
//  --------  ---  --------------  --------------------------------------
//  in_ch     in   valid / ready   cmd (0 alloc, 1 clear), request_size
//  out_ch    out  valid / ready   found, bin_number (one-based)
//  cfg_*     in   cfg_we          cfg_index, cfg_data
//
//  Allocate: the word walks down the tree one level at a time (RAM read,
//    compare, steer), then back up, each level folding the sibling max
//    into the parent; no new word is taken until the result is loaded.
//  Clear: one leaf of every level written per cycle.
//  Reset runs the same sweep with zero capacity, with in_ch.ready low;
//    config writes are taken during it.
//  A finished result sits in the output register; the next word is taken
//    meanwhile, and a second result waits internally until out_ch drains.
//
module first_fit_bin_allocator import ffba_pkg::*; #(
  parameter int NUM_BINS   = NUM_BINS_DEF,
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ffba_req_if.sink             in_ch,
  ffba_res_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IW = $clog2(NUM_BINS);  // tree depth, leaf index width
  localparam int SW = SIZE_WIDTH;
  localparam int UW = IW + 1;            // bins-in-use count

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SWEEP = 4'b0010,
    S_WALK  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // config
  logic [CFG_W-1:0] bin_cap_r;
  logic [CNT_W-1:0] item_limit_r;
  logic [NB_W-1:0]  num_bins_r;
  logic [UW-1:0]    used;

  // control
  state_t           state_r, state_nxt;
  logic [IW-1:0]    sweep_cnt_r;
  logic             sweep_cmd_r;   // sweep came from a clear word
  logic [SW-1:0]    sweep_cap_r;
  logic [UW-1:0]    sweep_used_r;
  logic             go_r;
  logic [SW-1:0]    size_r;
  logic             res_found_r;
  logic [BIN_W-1:0] res_bin_r;
  logic             out_valid_r;
  logic             out_found_r;
  logic [BIN_W-1:0] out_bin_r;

  logic             in_acc;
  logic             sweep_active;
  logic             sweep_last;
  logic             out_load;

  // level chain
  logic             dn_v [0:IW];
  logic [IW-1:0]    dn_i [0:IW];
  logic             up_v [0:IW];
  logic [SW-1:0]    up_d [0:IW];
  leaf_res_t        leaf_res;
  logic [IW-1:0]    leaf_idx;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cap_r    <= BIN_CAP_RST;
      item_limit_r <= ITEM_LIMIT_RST;
      num_bins_r   <= NUM_BINS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIN_CAPACITY: bin_cap_r    <= cfg_data;
        REG_ITEM_LIMIT:   item_limit_r <= cfg_data[CNT_W-1:0];
        REG_NUM_BINS:     num_bins_r   <= cfg_data[NB_W-1:0];
        default: ;
      endcase
    end
  end

  // num_bins saturates at NUM_BINS
  assign used = (32'(num_bins_r) >= 32'(NUM_BINS)) ? UW'(NUM_BINS) : UW'(num_bins_r);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign sweep_active = (state_r == S_SWEEP);
  assign sweep_last   = (sweep_cnt_r == {IW{1'b1}});
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_ch.cmd == CMD_CLEAR) ? S_SWEEP : S_WALK;
        end
      end
      S_SWEEP: begin
        if (sweep_last) begin
          state_nxt = sweep_cmd_r ? S_DONE : S_IDLE;
        end
      end
      S_WALK: begin
        // root cell has written back: the tree is consistent again
        if (up_v[0]) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_SWEEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      sweep_cnt_r  <= '0;
      sweep_cmd_r  <= 1'b0;
      sweep_cap_r  <= '0;
      sweep_used_r <= '0;
      go_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= in_acc && (in_ch.cmd == CMD_ALLOC);
      if (sweep_active) begin
        sweep_cnt_r <= sweep_cnt_r + 1'b1;
      end
      if (in_acc && (in_ch.cmd == CMD_CLEAR)) begin
        sweep_cnt_r  <= '0;
        sweep_cmd_r  <= 1'b1;
        sweep_cap_r  <= SW'(bin_cap_r);
        sweep_used_r <= used;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      size_r      <= SW'(in_ch.request_size);
      res_found_r <= 1'b0;
      res_bin_r   <= '0;
    end
    if (leaf_res.valid) begin
      res_found_r <= leaf_res.found;
      res_bin_r   <= leaf_res.found ? BIN_W'(32'(leaf_idx) + 32'd1) : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= res_found_r;
      out_bin_r   <= res_bin_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.bin_number = out_bin_r;

  // ---------------------------------------------------------------------------
  // tree: root at level 0, leaves at level IW
  // ---------------------------------------------------------------------------
  assign dn_v[0] = go_r;
  assign dn_i[0] = '0;

  for (genvar k = 0; k < IW; k++) begin : g_lvl
    ffba_cell #(
      .LEVEL (k),
      .IW    (IW),
      .SW    (SW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .sw_active    (sweep_active),
      .sw_idx       (sweep_cnt_r),
      .sw_cap       (sweep_cap_r),
      .sw_used      (sweep_used_r),
      .size         (size_r),
      .dn_valid     (dn_v[k]),
      .dn_idx       (dn_i[k]),
      .dn_out_valid (dn_v[k+1]),
      .dn_out_idx   (dn_i[k+1]),
      .up_valid     (up_v[k+1]),
      .up_val       (up_d[k+1]),
      .up_out_valid (up_v[k]),
      .up_out_val   (up_d[k])
    );
  end

  ffba_leaf #(
    .IW (IW),
    .SW (SW)
  ) u_leaf (
    .clk          (clk),
    .rst_n        (rst_n),
    .sw_active    (sweep_active),
    .sw_idx       (sweep_cnt_r),
    .sw_cap       (sweep_cap_r),
    .sw_used      (sweep_used_r),
    .size         (size_r),
    .used         (used),
    .item_limit   (item_limit_r),
    .dn_valid     (dn_v[IW]),
    .dn_idx       (dn_i[IW]),
    .res          (leaf_res),
    .res_idx      (leaf_idx),
    .up_out_valid (up_v[IW]),
    .up_out_val   (up_d[IW])
  );

endmodule

[rtl/ffba_checker.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffba_checker
// Port-level checks on the allocator's sequencing, bound to the top level.
// -----------------------------------------------------------------------------
module ffba_checker import ffba_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_found,
  input logic [BIN_W-1:0] out_bin_number
);

  // one word in flight: the input closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after accept");

  // clearing sweep follows reset
  a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("input ready during reset sweep");

  // a result never shows up the cycle after its word was taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too early");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
                                $stable(out_bin_number))
    else $error("stalled result changed");

endmodule

bind first_fit_bin_allocator ffba_checker u_ffba_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_found      (out_ch.found),
  .out_bin_number (out_ch.bin_number)
);
